FILE: hdl/dvd_pkg.sv
// Package: payload, command and status types for the duplicate value detector
`default_nettype none
package dvd_pkg;

  localparam int unsigned VALUE_W = 31;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic has_duplicate;
    logic overflow;
  } out_t;

  typedef struct packed {
    logic load;        // request taken; stored unless full, else overflow set
    logic pass_start;  // issue read of entry 0, clear swap flag
    logic pass_first;  // capture entry 0 as carry
    logic pass_run;    // compare carry with entry j, write smaller back
    logic pass_end;    // write carry into the top entry
    logic emit;        // load result register, clear set state
  } cmd_t;

  typedef struct packed {
    logic few;         // fewer than two stored values
    logic at_end;      // pass index on the top entry
    logic dup;         // equal neighbors seen
    logic swapped;     // current pass moved something
    logic out_busy;    // result register still held
  } sts_t;

endpackage
`default_nettype wire

FILE: hdl/dvd_ctrl.sv
// Controller: load, bubble pass sequencing and result hand-off
`default_nettype none
module dvd_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_last,
  output logic              in_ready,
  input  wire dvd_pkg::sts_t sts,
  output dvd_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_ENDP  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (sts.few) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt      = S_FIRST;
        end
      end
      S_FIRST: begin
        cmd.pass_first = 1'b1;
        state_nxt      = S_RUN;
      end
      S_RUN: begin
        cmd.pass_run = 1'b1;
        if (sts.at_end) begin
          state_nxt = S_ENDP;
        end
      end
      S_ENDP: begin
        cmd.pass_end = 1'b1;
        state_nxt    = (sts.dup || !sts.swapped) ? S_DONE : S_START;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.pass_start, cmd.pass_first, cmd.pass_run, cmd.pass_end, cmd.emit}))
    else $error("more than one datapath command");
  a_first_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pass_start |=> cmd.pass_first)
    else $error("pass did not capture entry 0");
  a_emit_only_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result overwritten");
`endif

endmodule
`default_nettype wire

FILE: hdl/dvd_dpath.sv
// Datapath: value store, count, bubble pass carry and compare, result register
`default_nettype none
module dvd_dpath #(
  parameter int unsigned MAX_VALUES = 128
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire dvd_pkg::in_t  in_data,
  input  wire dvd_pkg::cmd_t cmd,
  output dvd_pkg::sts_t     sts,
  output logic              out_valid,
  input  wire logic         out_ready,
  output dvd_pkg::out_t     out_data
);

  localparam int unsigned AW = $clog2(MAX_VALUES);
  localparam int unsigned CW = $clog2(MAX_VALUES + 1);
  localparam int unsigned VW = dvd_pkg::VALUE_W;

  logic [VW-1:0] mem [MAX_VALUES];

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          ovf_r;
  logic          ovf_nxt;
  logic [AW-1:0] j_r;
  logic [AW-1:0] j_nxt;
  logic [VW-1:0] carry_r;
  logic [VW-1:0] carry_nxt;
  logic          dup_r;
  logic          dup_nxt;
  logic          swp_r;
  logic          swp_nxt;
  logic          ov_r;
  logic          ov_nxt;
  dvd_pkg::out_t res_r;
  dvd_pkg::out_t res_nxt;
  logic [VW-1:0] rd_data_r;

  logic          full;
  logic [CW-1:0] top;
  logic          we;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic          gt;

  assign full = (count_r == CW'(MAX_VALUES));
  assign top  = count_r - CW'(1);
  assign gt   = (carry_r > rd_data_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_comb begin
    we        = 1'b0;
    waddr     = count_r[AW-1:0];
    wdata     = in_data.value;
    raddr     = j_r + AW'(1);
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    j_nxt     = j_r;
    carry_nxt = carry_r;
    dup_nxt   = dup_r;
    swp_nxt   = swp_r;
    ov_nxt    = ov_r;
    res_nxt   = res_r;
    if (cmd.load) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        we        = 1'b1;
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.pass_start) begin
      raddr   = '0;
      swp_nxt = 1'b0;
    end
    if (cmd.pass_first) begin
      raddr     = AW'(1);
      carry_nxt = rd_data_r;
      j_nxt     = AW'(1);
    end
    if (cmd.pass_run) begin
      we        = 1'b1;
      waddr     = j_r - AW'(1);
      wdata     = gt ? rd_data_r : carry_r;
      carry_nxt = gt ? carry_r : rd_data_r;
      swp_nxt   = swp_r | gt;
      dup_nxt   = dup_r | (carry_r == rd_data_r);
      j_nxt     = j_r + AW'(1);
    end
    if (cmd.pass_end) begin
      we    = 1'b1;
      waddr = top[AW-1:0];
      wdata = carry_r;
    end
    if (out_valid && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (cmd.emit) begin
      ov_nxt                = 1'b1;
      res_nxt.has_duplicate = dup_r;
      res_nxt.overflow      = ovf_r;
      count_nxt             = '0;
      ovf_nxt               = 1'b0;
      dup_nxt               = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      dup_r   <= 1'b0;
      swp_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      dup_r   <= dup_nxt;
      swp_r   <= swp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    carry_r <= carry_nxt;
    res_r   <= res_nxt;
  end

  assign sts.few      = (count_r < CW'(2));
  assign sts.at_end   = (CW'(j_r) == top);
  assign sts.dup      = dup_r;
  assign sts.swapped  = swp_r;
  assign sts.out_busy = ov_r && !out_ready;

  assign out_valid = ov_r;
  assign out_data  = res_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VALUES))
    else $error("store count past capacity");
  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pass_run |-> (CW'(j_r) < count_r) && (j_r != '0))
    else $error("pass index outside stored set");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (count_r == '0) && !ovf_r && !dup_r && ov_r)
    else $error("set state not cleared after result");
`endif

endmodule
`default_nettype wire

FILE: hdl/duplicate_value_detector.sv
// Top level: duplicate value detector, controller plus datapath
//
//   channel  ports                          direction  payload
//   in       in_valid, in_ready, in_data    request in  value[30:0], last
//   out      out_valid, out_ready, out_data result out has_duplicate, overflow
//
// Values load one per cycle into the store while in_ready is high. After the last
// value, the stored values run bubble passes on the store's one read and one
// write port, stopping after a pass with no swap or an equal neighbor pair;
// in_ready stays low through the passes and longer while a finished result waits
// on out_ready. A pending result does not block loading of the next set.
// Reset clears count and flags; store needs none.
`default_nettype none
module duplicate_value_detector #(
  parameter int unsigned MAX_VALUES = 128
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dvd_pkg::in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dvd_pkg::out_t out_data
);

  dvd_pkg::cmd_t cmd;
  dvd_pkg::sts_t sts;

  dvd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dvd_dpath #(
    .MAX_VALUES (MAX_VALUES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
